// ----- rtl/cpt_pkg.sv -----
// Package for the closest-point-on-triangle core: widths, payload types.
// No dependencies; every other file imports it.
package cpt_pkg;

  localparam int CW    = 32;            // coordinate width, signed Q16.16
  localparam int FRAC  = 16;            // fraction bits
  localparam int DISTW = 48;            // squared distance width, Q32.16

  localparam int DW    = CW + 1;        // coordinate difference
  localparam int PRW   = 2 * DW;        // one product of differences
  localparam int DOTW  = PRW + 2;       // dot product
  localparam int HW    = DOTW / 2;      // half of a dot product, for split multiply
  localparam int PPW   = 2 * HW + 2;    // partial product of a split multiply
  localparam int XPW   = 2 * DOTW;      // dot times dot
  localparam int XW    = XPW + 2;       // barycentric cross terms
  localparam int EW    = DOTW + 1;      // bc edge numerators
  localparam int NUMW  = XW + 2;        // divider operands
  localparam int DIVW  = NUMW + FRAC;   // quotient bits, one divider step each
  localparam int QW    = DIVW + 1;      // signed quotient
  localparam int CH    = 32;            // quotient chunk for the lerp multiply
  localparam int NCH   = (QW + CH - 1) / CH;
  localparam int QXW   = NCH * CH;
  localparam int MPW   = CH + 1 + DW;   // chunk times edge
  localparam int SUMW  = QXW + DW + 2;  // full lerp sum
  localparam int SQW   = 2 * DW;        // squared coordinate difference
  localparam int DSW   = SQW + 2;       // sum of squares

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [DW-1:0]   diff_t;
  typedef logic signed [NUMW-1:0] num_t;
  typedef logic signed [QW-1:0]   quot_t;

  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
    coord_t [2:0] p;
  } tri_t;

  // start point, query point and edges e1, e2 (either may be zero) for q = s + (v*e1 + w*e2) >> FRAC
  typedef struct packed {
    coord_t [2:0] s;
    coord_t [2:0] p;
    diff_t  [2:0] e1;
    diff_t  [2:0] e2;
  } lerp_t;

  typedef struct packed {
    num_t  num1;
    num_t  num2;
    num_t  den;
    lerp_t pl;
  } div_in_t;

  typedef struct packed {
    quot_t v;
    quot_t w;
    lerp_t pl;
  } div_out_t;

  typedef struct packed {
    coord_t           near_x;
    coord_t           near_y;
    coord_t           near_z;
    logic [DISTW-1:0] dist_sq;
  } result_t;

endpackage

// ----- rtl/cpt_if.sv -----
// Valid/ready channel interfaces for the closest-point core.
// Depends on cpt_pkg.
interface cpt_in_if import cpt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t ax, ay, az;
  coord_t bx, by_coord, bz;
  coord_t cx, cy, cz;
  coord_t px, py, pz;

  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                  input ready);
  modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                  output ready);
endinterface

interface cpt_out_if import cpt_pkg::*; ();
  logic             valid;
  logic             ready;
  coord_t           near_x, near_y, near_z;
  logic [DISTW-1:0] dist_sq;

  modport source (output valid, near_x, near_y, near_z, dist_sq, input ready);
  modport sink   (input valid, near_x, near_y, near_z, dist_sq, output ready);
endinterface

// ----- rtl/cpt_front.sv -----
// Front end: differences, dot products, cross terms, region select.
// Eight register stages; depends on cpt_pkg.
module cpt_front import cpt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  tri_t    tri_i,
  output logic    valid_o,
  output div_in_t div_o
);

  localparam int NST = 8;

  typedef struct packed {
    tri_t         t;
    diff_t  [2:0] ab;
    diff_t  [2:0] ac;
    diff_t  [2:0] bc;
  } geo_t;

  function automatic logic [3:0][PPW-1:0] mul_part(input logic [DOTW-1:0] x,
                                                   input logic [DOTW-1:0] y);
    logic signed [HW-1:0]  xh, yh;
    logic signed [HW:0]    xl, yl;
    logic signed [PPW-1:0] p0, p1, p2, p3;
    xh = $signed(x[DOTW-1:HW]);
    yh = $signed(y[DOTW-1:HW]);
    xl = $signed({1'b0, x[HW-1:0]});
    yl = $signed({1'b0, y[HW-1:0]});
    p0 = xh * yh;
    p1 = xh * yl;
    p2 = xl * yh;
    p3 = xl * yl;
    return {p0, p1, p2, p3};
  endfunction

  // operand pairs of the six dot-times-dot products
  localparam int ML [6] = '{0, 2, 4, 0, 2, 4};
  localparam int MR [6] = '{3, 1, 1, 5, 5, 3};

  logic [NST-1:0] vld_q;

  tri_t                          tri1_q;
  geo_t                          geo2_q, geo3_q, geo4_q, geo5_q, geo6_q, geo7_q;
  diff_t [2:0]                   ap2_q, bp2_q, cp2_q;
  logic [5:0][2:0][PRW-1:0]      pr3_q;
  logic [5:0][DOTW-1:0]          d4_q, d5_q, d6_q, d7_q;
  logic [5:0][3:0][PPW-1:0]      pp5_q;
  logic [5:0][XPW-1:0]           m6_q;
  logic signed [XW-1:0]          va7_q, vb7_q, vc7_q;
  logic signed [EW-1:0]          e17_q, e27_q;
  div_in_t                       div_d, div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tri1_q <= tri_i;

      geo2_q.t <= tri1_q;
      for (int i = 0; i < 3; i++) begin
        geo2_q.ab[i] <= $signed(tri1_q.b[i]) - $signed(tri1_q.a[i]);
        geo2_q.ac[i] <= $signed(tri1_q.c[i]) - $signed(tri1_q.a[i]);
        geo2_q.bc[i] <= $signed(tri1_q.c[i]) - $signed(tri1_q.b[i]);
        ap2_q[i]     <= $signed(tri1_q.p[i]) - $signed(tri1_q.a[i]);
        bp2_q[i]     <= $signed(tri1_q.p[i]) - $signed(tri1_q.b[i]);
        cp2_q[i]     <= $signed(tri1_q.p[i]) - $signed(tri1_q.c[i]);
      end

      geo3_q <= geo2_q;
      for (int i = 0; i < 3; i++) begin
        pr3_q[0][i] <= $signed(geo2_q.ab[i]) * $signed(ap2_q[i]);
        pr3_q[1][i] <= $signed(geo2_q.ac[i]) * $signed(ap2_q[i]);
        pr3_q[2][i] <= $signed(geo2_q.ab[i]) * $signed(bp2_q[i]);
        pr3_q[3][i] <= $signed(geo2_q.ac[i]) * $signed(bp2_q[i]);
        pr3_q[4][i] <= $signed(geo2_q.ab[i]) * $signed(cp2_q[i]);
        pr3_q[5][i] <= $signed(geo2_q.ac[i]) * $signed(cp2_q[i]);
      end

      geo4_q <= geo3_q;
      for (int j = 0; j < 6; j++) begin
        d4_q[j] <= $signed(pr3_q[j][0]) + $signed(pr3_q[j][1]) + $signed(pr3_q[j][2]);
      end

      geo5_q <= geo4_q;
      d5_q   <= d4_q;
      for (int j = 0; j < 6; j++) begin
        pp5_q[j] <= mul_part(d4_q[ML[j]], d4_q[MR[j]]);
      end

      geo6_q <= geo5_q;
      d6_q   <= d5_q;
      for (int j = 0; j < 6; j++) begin
        m6_q[j] <= ($signed(pp5_q[j][3]) <<< (2 * HW))
                 + (($signed(pp5_q[j][2]) + $signed(pp5_q[j][1])) <<< HW)
                 + $signed(pp5_q[j][0]);
      end

      geo7_q <= geo6_q;
      d7_q   <= d6_q;
      vc7_q  <= $signed(m6_q[0]) - $signed(m6_q[1]);
      vb7_q  <= $signed(m6_q[2]) - $signed(m6_q[3]);
      va7_q  <= $signed(m6_q[4]) - $signed(m6_q[5]);
      e17_q  <= $signed(d6_q[3]) - $signed(d6_q[2]);
      e27_q  <= $signed(d6_q[4]) - $signed(d6_q[5]);

      div_q <= div_d;
    end
  end

  // Voronoi region test, first match wins
  always_comb begin
    logic signed [DOTW-1:0] d1, d2, d3, d4, d5, d6;
    num_t                   den_int;
    d1 = $signed(d7_q[0]);
    d2 = $signed(d7_q[1]);
    d3 = $signed(d7_q[2]);
    d4 = $signed(d7_q[3]);
    d5 = $signed(d7_q[4]);
    d6 = $signed(d7_q[5]);
    den_int = NUMW'(va7_q) + NUMW'(vb7_q) + NUMW'(vc7_q);

    div_d.num1  = '0;
    div_d.num2  = '0;
    div_d.den   = '0;
    div_d.pl.s  = geo7_q.t.a;
    div_d.pl.p  = geo7_q.t.p;
    div_d.pl.e1 = '0;
    div_d.pl.e2 = '0;

    priority if (d1 <= 0 && d2 <= 0) begin
      div_d.pl.s = geo7_q.t.a;
    end else if (d3 >= 0 && d4 <= d3) begin
      div_d.pl.s = geo7_q.t.b;
    end else if (d6 >= 0 && d5 <= d6) begin
      div_d.pl.s = geo7_q.t.c;
    end else if (vc7_q <= 0 && d1 >= 0 && d3 <= 0) begin
      div_d.num1  = NUMW'(d1);
      div_d.den   = NUMW'(d1) - NUMW'(d3);
      div_d.pl.e1 = geo7_q.ab;
    end else if (vb7_q <= 0 && d2 >= 0 && d6 <= 0) begin
      div_d.num1  = NUMW'(d2);
      div_d.den   = NUMW'(d2) - NUMW'(d6);
      div_d.pl.e1 = geo7_q.ac;
    end else if (va7_q <= 0 && e17_q >= 0 && e27_q >= 0) begin
      div_d.num1  = NUMW'(e17_q);
      div_d.den   = NUMW'(e17_q) + NUMW'(e27_q);
      div_d.pl.s  = geo7_q.t.b;
      div_d.pl.e1 = geo7_q.bc;
    end else if (den_int != '0) begin
      div_d.num1  = NUMW'(vb7_q);
      div_d.num2  = NUMW'(vc7_q);
      div_d.den   = den_int;
      div_d.pl.e1 = geo7_q.ab;
      div_d.pl.e2 = geo7_q.ac;
    end else begin
      div_d.pl.s = geo7_q.t.a;  // degenerate triangle
    end
  end

  assign valid_o = vld_q[NST-1];
  assign div_o   = div_q;

endmodule

// ----- rtl/cpt_div.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage.
// q = trunc(num * 2^FRAC / den), zero for a zero denominator; depends on cpt_pkg.
module cpt_div import cpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  div_in_t  div_i,
  output logic     valid_o,
  output div_out_t div_o
);

  typedef struct packed {
    logic [NUMW-1:0] rem;
    logic [DIVW-1:0] dq;   // dividend bits shift out, quotient bits shift in
    logic            neg;
  } lane_t;

  typedef struct packed {
    lane_t           l1;
    lane_t           l2;
    logic [NUMW-1:0] d;
    logic            dz;
    lerp_t           pl;
  } dstage_t;

  function automatic logic [NUMW-1:0] mag(input num_t x);
    return x[NUMW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic lane_t step(input lane_t l, input logic [NUMW-1:0] d);
    logic [NUMW:0] r2;
    logic          ge;
    lane_t         o;
    r2     = {l.rem, l.dq[DIVW-1]};
    ge     = r2 >= {1'b0, d};
    o.rem  = ge ? NUMW'(r2 - {1'b0, d}) : NUMW'(r2);
    o.dq   = {l.dq[DIVW-2:0], ge};
    o.neg  = l.neg;
    return o;
  endfunction

  function automatic quot_t finish(input lane_t l, input logic dz);
    quot_t q;
    q = $signed({1'b0, l.dq});
    if (dz) begin
      q = '0;
    end else if (l.neg) begin
      q = -q;
    end
    return q;
  endfunction

  dstage_t         st_q [DIVW+1];
  logic [DIVW+1:0] vld_q;
  div_out_t        out_q;
  dstage_t         st0_d;

  always_comb begin
    st0_d.l1.rem = '0;
    st0_d.l1.dq  = {mag(div_i.num1), {FRAC{1'b0}}};
    st0_d.l1.neg = div_i.num1[NUMW-1] ^ div_i.den[NUMW-1];
    st0_d.l2.rem = '0;
    st0_d.l2.dq  = {mag(div_i.num2), {FRAC{1'b0}}};
    st0_d.l2.neg = div_i.num2[NUMW-1] ^ div_i.den[NUMW-1];
    st0_d.d      = mag(div_i.den);
    st0_d.dz     = div_i.den == '0;
    st0_d.pl     = div_i.pl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIVW:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
      for (int k = 0; k < DIVW; k++) begin
        st_q[k+1].l1 <= step(st_q[k].l1, st_q[k].d);
        st_q[k+1].l2 <= step(st_q[k].l2, st_q[k].d);
        st_q[k+1].d  <= st_q[k].d;
        st_q[k+1].dz <= st_q[k].dz;
        st_q[k+1].pl <= st_q[k].pl;
      end
      out_q.v  <= finish(st_q[DIVW].l1, st_q[DIVW].dz);
      out_q.w  <= finish(st_q[DIVW].l2, st_q[DIVW].dz);
      out_q.pl <= st_q[DIVW].pl;
    end
  end

  assign valid_o = vld_q[DIVW+1];
  assign div_o   = out_q;

endmodule

// ----- rtl/cpt_back.sv -----
// Back end: point = s + (v*e1 + w*e2) >> FRAC, coordinate clamp, squared distance.
// Four register stages plus an output adder; depends on cpt_pkg.
module cpt_back import cpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  div_out_t div_i,
  output logic     valid_o,
  output result_t  res_o
);

  localparam int NST = 4;

  function automatic logic [NCH-1:0][MPW-1:0] chunk_mul(input quot_t q, input diff_t e);
    logic signed [QXW-1:0]     qx;
    logic [NCH-1:0][MPW-1:0]   r;
    qx = QXW'(q);
    for (int i = 0; i < NCH; i++) begin
      if (i == NCH - 1) begin
        r[i] = $signed(qx[i*CH +: CH]) * $signed(e);
      end else begin
        r[i] = $signed({1'b0, qx[i*CH +: CH]}) * $signed(e);
      end
    end
    return r;
  endfunction

  logic [NST-1:0] vld_q;

  logic [2:0][NCH-1:0][MPW-1:0] pv1_q, pw1_q;
  coord_t [2:0]                 s1_q, s2_q, p1_q, p2_q, p3_q, q3_q, q4_q;
  logic [2:0][SUMW-1:0]         sv2_q, sw2_q;
  logic [2:0][SQW-1:0]          sq4_q;

  logic [2:0][SUMW-1:0]         sv_d, sw_d;
  coord_t [2:0]                 q_d;

  always_comb begin
    logic signed [SUMW-1:0] accv, accw;
    for (int c = 0; c < 3; c++) begin
      accv = '0;
      accw = '0;
      for (int i = 0; i < NCH; i++) begin
        accv = accv + ($signed(pv1_q[c][i]) <<< (CH * i));
        accw = accw + ($signed(pw1_q[c][i]) <<< (CH * i));
      end
      sv_d[c] = accv;
      sw_d[c] = accw;
    end
  end

  // add the start point, clamp to the signed coordinate range
  always_comb begin
    logic signed [SUMW-1:0] tot;
    for (int c = 0; c < 3; c++) begin
      tot = (($signed(sv2_q[c]) + $signed(sw2_q[c])) >>> FRAC) + $signed(s2_q[c]);
      if (tot[SUMW-1:CW-1] != '0 && tot[SUMW-1:CW-1] != '1) begin
        q_d[c] = tot[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        q_d[c] = tot[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        pv1_q[c] <= chunk_mul(div_i.v, div_i.pl.e1[c]);
        pw1_q[c] <= chunk_mul(div_i.w, div_i.pl.e2[c]);
      end
      s1_q  <= div_i.pl.s;
      p1_q  <= div_i.pl.p;

      sv2_q <= sv_d;
      sw2_q <= sw_d;
      s2_q  <= s1_q;
      p2_q  <= p1_q;

      q3_q  <= q_d;
      p3_q  <= p2_q;

      for (int c = 0; c < 3; c++) begin
        sq4_q[c] <= ($signed(p3_q[c]) - $signed(q3_q[c]))
                  * ($signed(p3_q[c]) - $signed(q3_q[c]));
      end
      q4_q <= q3_q;
    end
  end

  always_comb begin
    logic [DSW-1:0]      sum;
    logic [DSW-FRAC-1:0] shv;
    sum = DSW'(sq4_q[0]) + DSW'(sq4_q[1]) + DSW'(sq4_q[2]);
    shv = sum[DSW-1:FRAC];
    res_o.near_x  = q4_q[0];
    res_o.near_y  = q4_q[1];
    res_o.near_z  = q4_q[2];
    res_o.dist_sq = (shv[DSW-FRAC-1:DISTW] != '0) ? '1 : shv[DISTW-1:0];
  end

  assign valid_o = vld_q[NST-1];

endmodule

// ----- rtl/closest_point_on_triangle_core.sv -----
// Closest point on a 3D triangle to a query point, with the squared distance to it.
// Top level: front end, divider, back end and a two-entry output buffer; uses cpt_pkg.
//
// One item (vertices a, b, c and point p, signed Q16.16) enters per clock whenever
// in_i.ready is high, and results leave in order, one per item. Between acceptance
// and out_o.valid lie 8 front stages (differences, dot products, split 68x68 cross
// products, Voronoi region select), 158 divider stages (the two 156-bit restoring
// quotients of the edge or interior weights, one bit per stage), 4 back stages
// (lerp, clamp, squares) and the output buffer. The whole pipeline advances together
// while the two-entry output buffer has room, so input is taken even while a
// finished result waits for out_o.ready; once both entries are full, in_i.ready
// drops until one is taken. Degenerate triangles give vertex a (zero interior
// denominator) or the edge start vertex; out-of-range points clamp per coordinate,
// and dist_sq saturates at its maximum.
module closest_point_on_triangle_core import cpt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  cpt_in_if.sink           in_i,
  cpt_out_if.source        out_o
);

  logic     en;
  tri_t     tri_in;
  logic     fe_valid, dv_valid, bk_valid;
  div_in_t  fe_div;
  div_out_t dv_out;
  result_t  bk_res;

  // output buffer
  logic [1:0] cnt_q;
  result_t    head_q, tail_q;
  logic       push, pop;

  assign en = cnt_q != 2'd2;
  assign in_i.ready = en;

  assign tri_in.a = {in_i.az, in_i.ay, in_i.ax};
  assign tri_in.b = {in_i.bz, in_i.by_coord, in_i.bx};
  assign tri_in.c = {in_i.cz, in_i.cy, in_i.cx};
  assign tri_in.p = {in_i.pz, in_i.py, in_i.px};

  cpt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .tri_i   (tri_in),
    .valid_o (fe_valid),
    .div_o   (fe_div)
  );

  cpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_valid),
    .div_i   (fe_div),
    .valid_o (dv_valid),
    .div_o   (dv_out)
  );

  cpt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .div_i   (dv_out),
    .valid_o (bk_valid),
    .res_o   (bk_res)
  );

  assign push = bk_valid && en;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !pop) begin
      if (cnt_q == 2'd0) begin
        head_q <= bk_res;
      end else begin
        tail_q <= bk_res;
      end
    end else if (pop && !push) begin
      head_q <= tail_q;
    end else if (push && pop) begin
      if (cnt_q == 2'd1) begin
        head_q <= bk_res;
      end else begin
        head_q <= tail_q;
        tail_q <= bk_res;
      end
    end
  end

  assign out_o.valid   = cnt_q != 2'd0;
  assign out_o.near_x  = head_q.near_x;
  assign out_o.near_y  = head_q.near_y;
  assign out_o.near_z  = head_q.near_z;
  assign out_o.dist_sq = head_q.dist_sq;

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("buffer count did not grow on push");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("buffer count did not shrink on pop");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && cnt_q == 2'd0 |=> out_o.valid && out_o.dist_sq == $past(bk_res.dist_sq))
    else $error("item pushed into empty buffer not presented");

endmodule
